@@ rtl/core/fixed_point_alu_q24_8_defines.svh @@
// assertion macros for the fixed-point alu checker
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// checked only while out of reset
`define FPA_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FPA_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, opcodes and sizes of the signed fixed-point alu.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

    localparam int WordW       = 32;
    localparam int FuncW       = 4;
    localparam int FracBitsDef = 8;
    localparam int FqDepth     = 2;
    localparam int OqDepth     = 2;

    localparam logic [FuncW-1:0] OP_ADD     = 4'd0;
    localparam logic [FuncW-1:0] OP_SUB     = 4'd1;
    localparam logic [FuncW-1:0] OP_MUL     = 4'd2;
    localparam logic [FuncW-1:0] OP_DIV     = 4'd3;
    localparam logic [FuncW-1:0] OP_EQ      = 4'd4;
    localparam logic [FuncW-1:0] OP_NE      = 4'd5;
    localparam logic [FuncW-1:0] OP_GE      = 4'd6;
    localparam logic [FuncW-1:0] OP_LE      = 4'd7;
    localparam logic [FuncW-1:0] OP_GT      = 4'd8;
    localparam logic [FuncW-1:0] OP_LT      = 4'd9;
    localparam logic [FuncW-1:0] OP_INC     = 4'd10;
    localparam logic [FuncW-1:0] OP_DEC     = 4'd11;
    localparam logic [FuncW-1:0] OP_TOINT   = 4'd12;
    localparam logic [FuncW-1:0] OP_FROMINT = 4'd13;

    // class assigned by the front end
    typedef enum logic [1:0] {
        CLS_ALU,
        CLS_MUL,
        CLS_DIV,
        CLS_DIVZ
    } cls_t;

    typedef struct packed {
        cls_t                     cls;
        logic [FuncW-1:0]         func;
        logic signed [WordW-1:0]  a;
        logic signed [WordW-1:0]  b;
    } op_t;

    // head of the front queue as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

    typedef struct packed {
        logic signed [WordW-1:0] res;
        logic                    cmp;
        logic                    dz;
    } rslt_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

`default_nettype wire

@@ rtl/core/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front
    import fpa_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [FuncW-1:0]        func,
    input  wire logic signed [WordW-1:0] operand_a,
    input  wire logic signed [WordW-1:0] operand_b,
    output head_t                        head,
    input  wire logic                    head_pop
);

    localparam int PtrW = $clog2(FqDepth);
    localparam int CntW = $clog2(FqDepth + 1);

    op_t            ent_reg [FqDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    op_t            op_in;
    logic           wr_en;
    logic           rd_en;

    // classify the incoming item
    always_comb
    begin
        op_in.func = func;
        op_in.a    = operand_a;
        op_in.b    = operand_b;
        case (func)
            OP_MUL:  op_in.cls = CLS_MUL;
            OP_DIV:  op_in.cls = (operand_b == '0) ? CLS_DIVZ : CLS_DIV;
            default: op_in.cls = CLS_ALU;
        endcase
    end

    assign full   = (cnt_reg == CntW'(FqDepth));
    assign wr_en  = push && !full;
    assign rd_en  = head_pop && (cnt_reg != '0);
    assign head.valid = (cnt_reg != '0);
    assign head.op    = ent_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CntW'(wr_en) - CntW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fpa_div.sv @@
// ----------------------------------------------------------------------------
// fpa_div
// Restoring divider, one quotient bit per cycle, for scaled signed divide.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FracBitsDef
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [WordW-1:0] a,
    input  wire logic signed [WordW-1:0] b,
    input  wire logic                    take,
    output logic                         idle,
    output logic                         done,
    output logic signed [WordW-1:0]      quot
);

    localparam int DvdW = WordW + FRACTION_BITS;
    localparam int CntW = $clog2(DvdW + 1);

    div_state_t      state_reg, state_next;
    logic [DvdW-1:0] dvd_reg;
    logic [WordW:0]  rem_reg;
    logic [WordW-1:0] dvs_reg;
    logic            neg_reg;
    logic [CntW-1:0] cnt_reg;
    logic [WordW-1:0] abs_a;
    logic [WordW-1:0] abs_b;
    logic [WordW:0]  rem_sh;
    logic [WordW+1:0] diff;
    logic            qbit;

    assign abs_a  = a[WordW-1] ? WordW'(-a) : WordW'(a);
    assign abs_b  = b[WordW-1] ? WordW'(-b) : WordW'(b);
    assign rem_sh = {rem_reg[WordW-1:0], dvd_reg[DvdW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign qbit   = !diff[WordW+1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == CntW'(1)) state_next = DIV_DONE;
            DIV_DONE: if (take) state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        idle = 1'b0;
        done = 1'b0;
        case (state_reg)
            DIV_IDLE: idle = 1'b1;
            DIV_DONE: done = 1'b1;
            default:  ;
        endcase
        quot = neg_reg ? -$signed(dvd_reg[WordW-1:0]) : $signed(dvd_reg[WordW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DIV_IDLE && start)
            begin
                cnt_reg <= CntW'(DvdW);
            end
            else if (state_reg == DIV_RUN)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // shift-subtract datapath, quotient shifts in behind the dividend
    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            dvd_reg <= DvdW'(abs_a) << FRACTION_BITS;
            rem_reg <= '0;
            dvs_reg <= abs_b;
            neg_reg <= a[WordW-1] ^ b[WordW-1];
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_reg <= qbit ? diff[WordW:0] : rem_sh;
            dvd_reg <= {dvd_reg[DvdW-2:0], qbit};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back
// Executes queued items and holds results in a short output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FracBitsDef
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire head_t              head,
    output logic                    head_pop,
    input  wire logic               pop,
    output logic                    empty,
    output rslt_t                   out
);

    localparam int PtrW = $clog2(OqDepth);
    localparam int CntW = $clog2(OqDepth + 1);
    localparam logic [WordW-1:0] Bias = WordW'((64'd1 << FRACTION_BITS) - 64'd1);

    logic                    s1_valid_reg;
    logic                    s1_mul_reg;
    logic signed [WordW-1:0] s1_res_reg;
    logic signed [2*WordW-1:0] s1_prod_reg;
    logic                    s1_cmp_reg;
    logic                    s1_dz_reg;

    rslt_t           oq_reg [OqDepth];
    logic [PtrW-1:0] oq_wr_reg, oq_rd_reg;
    logic [CntW-1:0] oq_cnt_reg;

    logic                    s1_move;
    logic                    s1_free;
    logic                    issue_alu;
    logic                    div_start;
    logic                    div_idle;
    logic                    div_done;
    logic signed [WordW-1:0] div_quot;
    logic                    oq_pop;
    logic signed [WordW-1:0] alu_res;
    logic                    alu_cmp;
    logic signed [WordW-1:0] toint_sum;
    logic signed [2*WordW-1:0] prod_sh;
    rslt_t                   s1_out;

    fpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (head.op.a),
        .b     (head.op.b),
        .take  (s1_free),
        .idle  (div_idle),
        .done  (div_done),
        .quot  (div_quot)
    );

    // issue control, divide keeps order by blocking the queue head
    assign oq_pop    = pop && (oq_cnt_reg != '0);
    assign s1_move   = s1_valid_reg && (oq_cnt_reg != CntW'(OqDepth));
    assign s1_free   = !s1_valid_reg || s1_move;
    assign issue_alu = head.valid && div_idle && (head.op.cls != CLS_DIV) && s1_free;
    assign div_start = head.valid && div_idle && (head.op.cls == CLS_DIV);
    assign head_pop  = issue_alu || div_start;

    // combinational operations
    assign toint_sum = head.op.a + (head.op.a[WordW-1] ? $signed(Bias) : $signed(WordW'(0)));
    always_comb
    begin
        alu_res = '0;
        alu_cmp = 1'b0;
        case (head.op.func)
            OP_ADD:     alu_res = head.op.a + head.op.b;
            OP_SUB:     alu_res = head.op.a - head.op.b;
            OP_EQ:      alu_cmp = (head.op.a == head.op.b);
            OP_NE:      alu_cmp = (head.op.a != head.op.b);
            OP_GE:      alu_cmp = (head.op.a >= head.op.b);
            OP_LE:      alu_cmp = (head.op.a <= head.op.b);
            OP_GT:      alu_cmp = (head.op.a > head.op.b);
            OP_LT:      alu_cmp = (head.op.a < head.op.b);
            OP_INC:     alu_res = head.op.a + 32'sd1;
            OP_DEC:     alu_res = head.op.a - 32'sd1;
            OP_TOINT:   alu_res = toint_sum >>> FRACTION_BITS;
            OP_FROMINT: alu_res = head.op.a <<< FRACTION_BITS;
            default:    ;
        endcase
    end

    // execute stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= div_done || issue_alu;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_mul_reg  <= !div_done && head.op.cls == CLS_MUL;
            s1_prod_reg <= head.op.a * head.op.b;
            s1_res_reg  <= div_done ? div_quot : alu_res;
            s1_cmp_reg  <= !div_done && alu_cmp;
            s1_dz_reg   <= !div_done && head.op.cls == CLS_DIVZ;
        end
    end

    // product scaling on the way out of the execute stage
    assign prod_sh = s1_prod_reg >>> FRACTION_BITS;
    always_comb
    begin
        s1_out.res = s1_mul_reg ? prod_sh[WordW-1:0] : s1_res_reg;
        s1_out.cmp = s1_cmp_reg;
        s1_out.dz  = s1_dz_reg;
    end

    // output queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (s1_move) oq_wr_reg <= oq_wr_reg + 1'b1;
            if (oq_pop)  oq_rd_reg <= oq_rd_reg + 1'b1;
            oq_cnt_reg <= oq_cnt_reg + CntW'(s1_move) - CntW'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            oq_reg[oq_wr_reg] <= s1_out;
        end
    end

    assign empty = (oq_cnt_reg == '0);
    assign out   = oq_reg[oq_rd_reg];

endmodule

`default_nettype wire

@@ rtl/core/fixed_point_alu_q24_8.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed 32-bit fixed-point alu with a decoupled front end and execute unit.
// ----------------------------------------------------------------------------
// channel   handshake           payload
// input     push / full         func, operand_a, operand_b
// result    pop / empty         result_raw, compare_true, divide_by_zero
//
// one item per cycle for all operations but divide, while no result is stalled;
// results pass the front queue, the execute stage and the output queue. divide runs
// on a bit-serial divider and blocks later items until it finishes so order is kept.
// reset clears both queues and the divider; no clearing pass.
// a stalled result side fills the output queue, then the front queue, then full.
`default_nettype none

module fixed_point_alu_q24_8
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FracBitsDef
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [FuncW-1:0]        func,
    input  wire logic signed [WordW-1:0] operand_a,
    input  wire logic signed [WordW-1:0] operand_b,
    input  wire logic                    pop,
    output logic                         empty,
    output logic signed [WordW-1:0]      result_raw,
    output logic                         compare_true,
    output logic                         divide_by_zero
);

    head_t head;
    logic  head_pop;
    rslt_t out;

    // front end
    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .head      (head),
        .head_pop  (head_pop)
    );

    // execute unit
    fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_pop (head_pop),
        .pop      (pop),
        .empty    (empty),
        .out      (out)
    );

    assign result_raw     = out.res;
    assign compare_true   = out.cmp;
    assign divide_by_zero = out.dz;

endmodule

`default_nettype wire

@@ rtl/core/fpa_checker.sv @@
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point alu, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_point_alu_q24_8_defines.svh"

module fpa_checker
    import fpa_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    push,
    input wire logic                    full,
    input wire logic [FuncW-1:0]        func,
    input wire logic signed [WordW-1:0] operand_a,
    input wire logic signed [WordW-1:0] operand_b,
    input wire logic                    pop,
    input wire logic                    empty,
    input wire logic signed [WordW-1:0] result_raw,
    input wire logic                    compare_true,
    input wire logic                    divide_by_zero
);

    // nothing waits on the result side during reset
    `FPA_ASSERT_ALL(a_rst_empty, !rst_n |-> empty, "result shown during reset")

    // a zero divisor never carries a compare outcome
    `FPA_ASSERT_RUN(a_flags_excl, !empty |-> !(compare_true && divide_by_zero), "both flags set")

    // zero divisor and compare results carry a zero raw value
    `FPA_ASSERT_RUN(a_flag_zero, (!empty && (divide_by_zero || compare_true)) |-> (result_raw == '0), "flagged result not zero")

    // a waiting result holds until its transfer
    `FPA_ASSERT_RUN(a_hold, (!empty && !pop) |=> (!empty && $stable(result_raw)), "waiting result changed")

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (.*);

`default_nettype wire
